// ----- sv/sdalu_pkg.sv -----
// Shared types and constants of the scaled decimal ALU.
package sdalu_pkg;

    localparam int COEFF_BITS_DEF = 128;
    localparam logic [5:0] DIVIDE_PLACES_RESET = 6'd10;
    localparam logic [8:0] SCALE_MAX = 9'd255;
    localparam logic [3:0] DIGIT_TEN = 4'd10;
    localparam logic [3:0] ROUND_HALF = 4'd5;

    typedef enum logic [2:0] {
        F_ADD   = 3'd0,
        F_SUB   = 3'd1,
        F_MUL   = 3'd2,
        F_DIV   = 3'd3,
        F_MOD   = 3'd4,
        F_CMP   = 3'd5,
        F_ROUND = 3'd6,
        F_TRUNC = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } order_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_MULP  = 7'b0000100,
        S_MULA  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_TEN   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

endpackage

// ----- sv/scaled_decimal_alu_core.sv -----
// Top level of the scaled decimal ALU: sequencer around one shared arithmetic unit.
// Add, sub and compare scale the smaller-scale operand up by 10^|a_scale - b_scale|; modulo then
// also runs a bitwise restoring division; divide scales the dividend up by 10^(divide_places
// + max(0, b_scale - a_scale)) and then divides; multiply alternates partial product and
// accumulate per 32x32 chunk pair; round, truncate divide by ten byte-wise per dropped digit. Zero
// divisor, scale overflow and no dropped digits go straight to finish. Input is taken again once
// the result registers; out_stall holds finish. Reset (rst_n, async) idles, divide_places = 10.
module scaled_decimal_alu_core #(
    parameter int COEFF_BITS = sdalu_pkg::COEFF_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [63:0] a_low,
    input  logic [63:0] a_high,
    input  logic [7:0]  a_scale,
    input  logic        a_negative,
    input  logic [63:0] b_low,
    input  logic [63:0] b_high,
    input  logic [7:0]  b_scale,
    input  logic        b_negative,
    input  logic [7:0]  target_places,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] res_low,
    output logic [63:0] res_high,
    output logic [7:0]  res_scale,
    output logic        res_negative,
    output logic [1:0]  order,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    localparam int W   = COEFF_BITS;
    localparam int NC  = (W + 31) / 32;
    localparam int CW  = (NC > 1) ? $clog2(NC) : 1;
    localparam int XW  = NC * 32;
    localparam int PAD = ((W + 7) / 8) * 8;
    localparam int NB  = PAD / 8;
    localparam int SW  = $clog2(W + 1);
    localparam int SHW = W + 96;

    sdalu_pkg::state_t  state_reg, state_next;
    sdalu_pkg::func_t   func_reg;
    sdalu_pkg::status_t st_reg;
    logic [W-1:0]   x_reg, y_reg;
    logic [W:0]     rem_reg;
    logic [PAD-1:0] tq_reg;
    logic [3:0]     trem_reg;
    logic [63:0]    prod_reg;
    logic [CW-1:0]  i_reg, j_reg;
    logic [SW-1:0]  step_reg;
    logic [8:0]     cnt_reg;
    logic [8:0]     rs_reg;
    logic           sel_a_reg, an_reg, bn_reg, az_reg, bz_reg;
    logic [5:0]     places_reg;

    logic           out_valid_reg;
    logic [W-1:0]   out_coef_reg;
    logic [7:0]     out_scale_reg;
    logic           out_neg_reg;
    sdalu_pkg::order_t  out_ord_reg;
    sdalu_pkg::status_t out_st_reg;

    logic [127:0]   coef_a, coef_b;
    logic [W-1:0]   fa, fb;
    logic           in_fire, a_zero, b_zero, a_gt_b;
    logic [7:0]     common;
    logic [8:0]     gap, mul_scale, div_scale, div_cnt;
    sdalu_pkg::func_t in_func;

    logic [W-1:0]   scaled;
    logic [W:0]     rem_shift;
    logic           rem_ge;
    logic [XW-1:0]  x_wide, y_wide;
    logic [31:0]    chunk_a, chunk_b;
    logic [CW:0]    pos, j_last;
    logic [SHW-1:0] p_sh;
    logic [7:0]     qbyte;
    logic [3:0]     dig_rem;
    logic           fin_go;

    logic [W-1:0]   sum_r, add_r, rnd_r, fin_coef;
    logic           x_ge_y, x_eq_y, add_n, fin_neg, round_up;
    sdalu_pkg::order_t fin_ord;

    assign in_stall  = (state_reg != sdalu_pkg::S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign coef_a = {a_high, a_low};
    assign coef_b = {b_high, b_low};
    assign fa     = coef_a[W-1:0];
    assign fb     = coef_b[W-1:0];
    assign a_zero = (fa == '0);
    assign b_zero = (fb == '0);
    assign a_gt_b = (a_scale > b_scale);
    assign common = a_gt_b ? a_scale : b_scale;
    assign gap    = a_gt_b ? {1'b0, a_scale - b_scale} : {1'b0, b_scale - a_scale};
    assign mul_scale = {1'b0, a_scale} + {1'b0, b_scale};
    assign div_scale = {3'b000, places_reg} + (a_gt_b ? gap : 9'd0);
    assign div_cnt   = {3'b000, places_reg} + (a_gt_b ? 9'd0 : gap);
    assign in_func   = sdalu_pkg::func_t'(func);

    assign scaled    = sel_a_reg ? ((x_reg << 3) + (x_reg << 1))
                                 : ((y_reg << 3) + (y_reg << 1));
    assign rem_shift = {rem_reg[W-1:0], x_reg[W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, y_reg});

    assign x_wide  = XW'(x_reg);
    assign y_wide  = XW'(y_reg);
    assign chunk_a = x_wide[i_reg*32 +: 32];
    assign chunk_b = y_wide[j_reg*32 +: 32];
    assign pos     = {1'b0, i_reg} + {1'b0, j_reg};
    assign j_last  = (CW + 1)'(NC - 1) - {1'b0, i_reg};
    assign p_sh    = SHW'(prod_reg) << {pos, 5'b00000};

    always_comb
    begin
        logic [4:0] v;
        logic [3:0] r;
        r = trem_reg;
        qbyte = '0;
        for (int k = 0; k < 8; k++)
        begin
            v = {r, tq_reg[PAD-1-k]};
            if (v >= {1'b0, sdalu_pkg::DIGIT_TEN})
            begin
                v = v - {1'b0, sdalu_pkg::DIGIT_TEN};
                qbyte[7-k] = 1'b1;
            end
            r = v[3:0];
        end
        dig_rem = r;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdalu_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_func)
                        sdalu_pkg::F_MUL:
                            state_next = (mul_scale > sdalu_pkg::SCALE_MAX)
                                         ? sdalu_pkg::S_FIN : sdalu_pkg::S_MULP;
                        sdalu_pkg::F_DIV:
                            state_next = (b_zero || div_scale > sdalu_pkg::SCALE_MAX)
                                         ? sdalu_pkg::S_FIN : sdalu_pkg::S_SCALE;
                        sdalu_pkg::F_MOD:
                            state_next = b_zero ? sdalu_pkg::S_FIN : sdalu_pkg::S_SCALE;
                        sdalu_pkg::F_ROUND, sdalu_pkg::F_TRUNC:
                            state_next = (target_places < a_scale)
                                         ? sdalu_pkg::S_TEN : sdalu_pkg::S_FIN;
                        default:
                            state_next = sdalu_pkg::S_SCALE;
                    endcase
                end
            end
            sdalu_pkg::S_SCALE:
            begin
                if (cnt_reg == '0)
                    state_next = (func_reg == sdalu_pkg::F_MOD || func_reg == sdalu_pkg::F_DIV)
                                 ? sdalu_pkg::S_DIV : sdalu_pkg::S_FIN;
            end
            sdalu_pkg::S_MULP:
                state_next = sdalu_pkg::S_MULA;
            sdalu_pkg::S_MULA:
                state_next = ({1'b0, j_reg} == j_last && i_reg == CW'(NC - 1))
                             ? sdalu_pkg::S_FIN : sdalu_pkg::S_MULP;
            sdalu_pkg::S_DIV:
                if (step_reg == SW'(W - 1))
                    state_next = sdalu_pkg::S_FIN;
            sdalu_pkg::S_TEN:
                if (step_reg == SW'(NB - 1) && cnt_reg == 9'd1)
                    state_next = sdalu_pkg::S_FIN;
            sdalu_pkg::S_FIN:
                if (fin_go)
                    state_next = sdalu_pkg::S_IDLE;
            default:
                state_next = sdalu_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        sum_r  = x_reg + y_reg;
        x_ge_y = (x_reg >= y_reg);
        x_eq_y = (x_reg == y_reg);
        if (an_reg == bn_reg)
        begin
            add_r = sum_r;
            add_n = an_reg;
        end
        else if (x_ge_y)
        begin
            add_r = x_reg - y_reg;
            add_n = an_reg;
        end
        else
        begin
            add_r = y_reg - x_reg;
            add_n = bn_reg;
        end

        priority if (az_reg && bz_reg)
            fin_ord = sdalu_pkg::ORD_EQUAL;
        else if (az_reg)
            fin_ord = bn_reg ? sdalu_pkg::ORD_GREATER : sdalu_pkg::ORD_LESS;
        else if (bz_reg)
            fin_ord = an_reg ? sdalu_pkg::ORD_LESS : sdalu_pkg::ORD_GREATER;
        else if (an_reg != bn_reg)
            fin_ord = an_reg ? sdalu_pkg::ORD_LESS : sdalu_pkg::ORD_GREATER;
        else if (x_eq_y)
            fin_ord = sdalu_pkg::ORD_EQUAL;
        else if (x_ge_y != an_reg)
            fin_ord = sdalu_pkg::ORD_GREATER;
        else
            fin_ord = sdalu_pkg::ORD_LESS;

        round_up = (func_reg == sdalu_pkg::F_ROUND) && (trem_reg >= sdalu_pkg::ROUND_HALF);
        rnd_r    = tq_reg[W-1:0] + W'(round_up);

        fin_coef = '0;
        fin_neg  = 1'b0;
        unique case (func_reg)
            sdalu_pkg::F_ADD, sdalu_pkg::F_SUB:
            begin
                fin_coef = add_r;
                fin_neg  = add_n;
            end
            sdalu_pkg::F_MUL:
            begin
                fin_coef = rem_reg[W-1:0];
                fin_neg  = an_reg ^ bn_reg;
            end
            sdalu_pkg::F_DIV:
            begin
                fin_coef = x_reg;
                fin_neg  = an_reg ^ bn_reg;
            end
            sdalu_pkg::F_MOD:
            begin
                fin_coef = rem_reg[W-1:0];
                fin_neg  = an_reg;
            end
            sdalu_pkg::F_CMP:
            begin
                fin_coef = '0;
                fin_neg  = 1'b0;
            end
            sdalu_pkg::F_ROUND, sdalu_pkg::F_TRUNC:
            begin
                fin_coef = rnd_r;
                fin_neg  = an_reg;
            end
            default:
            begin
                fin_coef = '0;
                fin_neg  = 1'b0;
            end
        endcase
        if (st_reg != sdalu_pkg::ST_OK)
        begin
            fin_coef = '0;
            fin_neg  = 1'b0;
        end
        if (fin_coef == '0)
            fin_neg = 1'b0;
    end

    assign fin_go = (state_reg == sdalu_pkg::S_FIN) && !(out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdalu_pkg::S_IDLE;
            places_reg    <= sdalu_pkg::DIVIDE_PLACES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                places_reg <= cfg_data;
            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sdalu_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    func_reg  <= (in_func == sdalu_pkg::F_SUB) ? sdalu_pkg::F_ADD : in_func;
                    x_reg     <= fa;
                    y_reg     <= fb;
                    an_reg    <= a_negative;
                    bn_reg    <= (in_func == sdalu_pkg::F_SUB) ? (b_negative ^ !b_zero)
                                                               : b_negative;
                    az_reg    <= a_zero;
                    bz_reg    <= b_zero;
                    tq_reg    <= PAD'(fa);
                    trem_reg  <= '0;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    sel_a_reg <= !a_gt_b;
                    cnt_reg   <= gap;
                    rs_reg    <= {1'b0, common};
                    st_reg    <= sdalu_pkg::ST_OK;
                    unique case (in_func)
                        sdalu_pkg::F_MUL:
                        begin
                            rs_reg <= mul_scale;
                            if (mul_scale > sdalu_pkg::SCALE_MAX)
                                st_reg <= sdalu_pkg::ST_OVERFLOW;
                        end
                        sdalu_pkg::F_DIV:
                        begin
                            rs_reg    <= div_scale;
                            cnt_reg   <= div_cnt;
                            sel_a_reg <= 1'b1;
                            if (b_zero)
                                st_reg <= sdalu_pkg::ST_DIV_ZERO;
                            else if (div_scale > sdalu_pkg::SCALE_MAX)
                                st_reg <= sdalu_pkg::ST_OVERFLOW;
                        end
                        sdalu_pkg::F_MOD:
                        begin
                            if (b_zero)
                                st_reg <= sdalu_pkg::ST_DIV_ZERO;
                        end
                        sdalu_pkg::F_CMP:
                            rs_reg <= '0;
                        sdalu_pkg::F_ROUND, sdalu_pkg::F_TRUNC:
                        begin
                            if (target_places < a_scale)
                            begin
                                rs_reg  <= {1'b0, target_places};
                                cnt_reg <= {1'b0, a_scale - target_places};
                            end
                            else
                                rs_reg <= {1'b0, a_scale};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sdalu_pkg::S_SCALE:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 9'd1;
                    if (sel_a_reg)
                        x_reg <= scaled;
                    else
                        y_reg <= scaled;
                end
            end
            sdalu_pkg::S_MULP:
                prod_reg <= chunk_a * chunk_b;
            sdalu_pkg::S_MULA:
            begin
                rem_reg <= {1'b0, rem_reg[W-1:0] + p_sh[W-1:0]};
                if ({1'b0, j_reg} == j_last)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + CW'(1);
                end
                else
                    j_reg <= j_reg + CW'(1);
            end
            sdalu_pkg::S_DIV:
            begin
                rem_reg  <= rem_ge ? (rem_shift - {1'b0, y_reg}) : rem_shift;
                x_reg    <= {x_reg[W-2:0], rem_ge};
                step_reg <= step_reg + SW'(1);
            end
            sdalu_pkg::S_TEN:
            begin
                tq_reg   <= {tq_reg[PAD-9:0], qbyte};
                trem_reg <= dig_rem;
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(NB - 1))
                begin
                    step_reg <= '0;
                    if (cnt_reg != 9'd1)
                    begin
                        cnt_reg  <= cnt_reg - 9'd1;
                        trem_reg <= '0;
                    end
                end
            end
            sdalu_pkg::S_FIN:
            begin
                if (fin_go)
                begin
                    out_coef_reg  <= fin_coef;
                    out_neg_reg   <= fin_neg;
                    out_scale_reg <= (st_reg != sdalu_pkg::ST_OK) ? 8'd0 : rs_reg[7:0];
                    out_ord_reg   <= (func_reg == sdalu_pkg::F_CMP) ? fin_ord
                                                                    : sdalu_pkg::ORD_LESS;
                    out_st_reg    <= st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign res_low      = 64'(128'(out_coef_reg));
    assign res_high     = 64'(128'(out_coef_reg) >> 64);
    assign res_scale    = out_scale_reg;
    assign res_negative = out_neg_reg;
    assign order        = out_ord_reg;
    assign status       = out_st_reg;

    a_err_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != sdalu_pkg::ST_OK |->
            res_low == 64'd0 && res_high == 64'd0 && res_scale == 8'd0 && !res_negative)
        else $error("error status with nonzero result");

    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_low == 64'd0 && res_high == 64'd0 |-> !res_negative)
        else $error("negative zero result");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sdalu_pkg::S_DIV && y_reg != '0 |-> rem_reg < {1'b0, y_reg})
        else $error("partial remainder not below divisor");

    a_ten_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sdalu_pkg::S_TEN |-> trem_reg < sdalu_pkg::DIGIT_TEN)
        else $error("decimal digit remainder out of range");

endmodule
